// ===== design/rvx_pkg.sv =====
package rvx_pkg;

	// action classes
	localparam logic [3:0] ACT_REGREG = 4'd0;
	localparam logic [3:0] ACT_REGIMM = 4'd1;
	localparam logic [3:0] ACT_LOAD   = 4'd2;
	localparam logic [3:0] ACT_JALR   = 4'd3;
	localparam logic [3:0] ACT_STORE  = 4'd4;
	localparam logic [3:0] ACT_BRANCH = 4'd5;
	localparam logic [3:0] ACT_LUI    = 4'd6;
	localparam logic [3:0] ACT_AUIPC  = 4'd7;
	localparam logic [3:0] ACT_JAL    = 4'd8;

	localparam logic [6:0] F7_BASE = 7'd0;
	localparam logic [6:0] F7_MEXT = 7'd1;
	localparam logic [6:0] F7_ALT  = 7'd32;

	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [31:0] MIN_INT  = 32'h8000_0000;
	localparam int          QDEPTH   = 4;
	localparam int          QPTR_W   = 2;

	// divider pipeline: DIV_STAGES stages of DIV_STEP quotient bits each (32 in total)
	localparam int          DIV_STAGES = 8;
	localparam int          DIV_STEP   = 4;

	// operation kinds the front part resolves for the back part
	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA,
		OP_OR, OP_AND, OP_MUL, OP_DIV, OP_ADDR, OP_BRANCH, OP_PASS, OP_BAD
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [2:0]  funct3;
		logic        clr_lsb;
		logic [31:0] opa;
		logic [31:0] opb;
		logic [31:0] pc;
		logic [31:0] imm;
	} uop_t;

	typedef struct packed {
		logic        invalid;
		logic [31:0] result;
	} res_t;

endpackage

// ===== design/rv32im_execute_alu.sv =====
// rv32im_execute_alu: execute result unit of an RV32IM core.
// Slave channel s_axis_*: one instruction per request (tdata fields below).
// Master channel m_axis_*: one result per request, in order: 32-bit result in
// tdata, the invalid flag in tuser (undefined combination, result all ones).
// A front part decodes each request into one operation and pushes it into a
// four-entry queue; the back part is an eight-stage pipeline (product formed
// on entry, divide four quotient bits per stage) followed by the result
// select and the output register. Every operation takes the same path.
// Throughput: one request per cycle while no result is stalled at the output.
// When m_axis_tready is low with a result pending, the result holds; the back
// stalls and the queue keeps accepting until its four entries are full, then
// s_axis_tready drops.
// Reset (arst_n low) empties the queue and pipeline; no result is pending.
module rv32im_execute_alu (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// action[3:0], funct3[6:4], funct7[13:7], immediate[45:14],
	// src_a[77:46], src_b[109:78], pc_value[141:110], zero fill to 144
	input  logic [143:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// result[31:0]
	output logic [31:0]  m_axis_tdata,
	// invalid[0]
	output logic         m_axis_tuser
);

	logic          q_valid, q_ready;
	rvx_pkg::uop_t q_uop;
	rvx_pkg::res_t res;

	rvx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.action    (s_axis_tdata[3:0]),
		.funct3    (s_axis_tdata[6:4]),
		.funct7    (s_axis_tdata[13:7]),
		.immediate (s_axis_tdata[45:14]),
		.src_a     (s_axis_tdata[77:46]),
		.src_b     (s_axis_tdata[109:78]),
		.pc_value  (s_axis_tdata[141:110]),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_uop     (q_uop)
	);

	rvx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_uop     (q_uop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = res.result;
	assign m_axis_tuser = res.invalid;

endmodule

// ===== design/rvx_front.sv =====
module rvx_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [3:0]        action,
	input  logic [2:0]        funct3,
	input  logic [6:0]        funct7,
	input  logic [31:0]       immediate,
	input  logic [31:0]       src_a,
	input  logic [31:0]       src_b,
	input  logic [31:0]       pc_value,
	output logic              q_valid,
	input  logic              q_ready,
	output rvx_pkg::uop_t     q_uop
);

	rvx_pkg::uop_t uop;
	rvx_pkg::uop_t mem_q [rvx_pkg::QDEPTH];
	logic [rvx_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [rvx_pkg::QPTR_W:0]   cnt_q;
	logic push, pop;

	// classify the request into one back-end operation
	always_comb begin
		uop.op      = rvx_pkg::OP_BAD;
		uop.funct3  = funct3;
		uop.clr_lsb = 1'b0;
		uop.opa     = src_a;
		uop.opb     = immediate;
		uop.pc      = pc_value;
		uop.imm     = immediate;
		case (action)
			rvx_pkg::ACT_REGREG: begin
				uop.opb = src_b;
				if (funct7 == rvx_pkg::F7_MEXT) begin
					uop.op = (funct3[2]) ? rvx_pkg::OP_DIV : rvx_pkg::OP_MUL;
				end else if (funct7 == rvx_pkg::F7_ALT) begin
					if (funct3 == 3'd0) uop.op = rvx_pkg::OP_SUB;
					else if (funct3 == 3'd5) uop.op = rvx_pkg::OP_SRA;
				end else if (funct7 == rvx_pkg::F7_BASE) begin
					case (funct3)
						3'd0: uop.op = rvx_pkg::OP_ADD;
						3'd1: uop.op = rvx_pkg::OP_SLL;
						3'd2: uop.op = rvx_pkg::OP_SLT;
						3'd3: uop.op = rvx_pkg::OP_SLTU;
						3'd4: uop.op = rvx_pkg::OP_XOR;
						3'd5: uop.op = rvx_pkg::OP_SRL;
						3'd6: uop.op = rvx_pkg::OP_OR;
						default: uop.op = rvx_pkg::OP_AND;
					endcase
				end
			end
			rvx_pkg::ACT_REGIMM: begin
				case (funct3)
					3'd0: uop.op = rvx_pkg::OP_ADD;
					3'd1: uop.op = rvx_pkg::OP_SLL;
					3'd2: uop.op = rvx_pkg::OP_SLT;
					3'd3: uop.op = rvx_pkg::OP_SLTU;
					3'd4: uop.op = rvx_pkg::OP_XOR;
					3'd5: uop.op = immediate[10] ? rvx_pkg::OP_SRA : rvx_pkg::OP_SRL;
					3'd6: uop.op = rvx_pkg::OP_OR;
					default: uop.op = rvx_pkg::OP_AND;
				endcase
			end
			rvx_pkg::ACT_LOAD, rvx_pkg::ACT_STORE: uop.op = rvx_pkg::OP_ADDR;
			rvx_pkg::ACT_JALR: begin
				uop.op      = rvx_pkg::OP_ADDR;
				uop.clr_lsb = 1'b1;
			end
			rvx_pkg::ACT_BRANCH: begin
				uop.opb = src_b;
				if (funct3 != 3'd2 && funct3 != 3'd3) uop.op = rvx_pkg::OP_BRANCH;
			end
			rvx_pkg::ACT_LUI: begin
				uop.op  = rvx_pkg::OP_PASS;
				uop.opa = 32'd0;
			end
			rvx_pkg::ACT_AUIPC, rvx_pkg::ACT_JAL: begin
				uop.op  = rvx_pkg::OP_ADDR;
				uop.opa = pc_value;
			end
			default: uop.op = rvx_pkg::OP_BAD;
		endcase
	end

	// request queue toward the back part
	assign in_ready = (cnt_q != rvx_pkg::QDEPTH[rvx_pkg::QPTR_W:0]);
	assign q_valid  = (cnt_q != '0);
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;
	assign q_uop    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= uop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {{rvx_pkg::QPTR_W{1'b0}}, push} - {{rvx_pkg::QPTR_W{1'b0}}, pop};
		end
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rvx_pkg::QDEPTH[rvx_pkg::QPTR_W:0])
		else $error("queue count overflow");
	a_cnt_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("push not counted");
	a_cnt_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("pop not counted");
`endif

endmodule

// ===== design/rvx_back.sv =====
module rvx_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  rvx_pkg::uop_t q_uop,
	output logic          out_valid,
	input  logic          out_ready,
	output rvx_pkg::res_t out_res
);

	// stages 1..DIV_STAGES: restoring divide, DIV_STEP quotient bits per stage;
	// the product is formed on entry and carried along
	// last stage feeds the result select and the output register
	logic [rvx_pkg::DIV_STAGES:1] v_s;
	rvx_pkg::uop_t u_s    [1:rvx_pkg::DIV_STAGES];
	logic [63:0]   prod_s [1:rvx_pkg::DIV_STAGES];
	logic [31:0]   rem_s  [1:rvx_pkg::DIV_STAGES];
	logic [31:0]   quo_s  [1:rvx_pkg::DIV_STAGES];
	logic [31:0]   dvs_s  [1:rvx_pkg::DIV_STAGES];
	logic          out_v_q;
	logic          adv;
	rvx_pkg::res_t res_c;

	logic signed [65:0] prod_w;
	logic [63:0] prod_c;
	logic [32:0] sa, sb;
	logic [31:0] ma, mb;
	logic        sgn;

	assign adv     = !out_v_q || out_ready;
	assign q_ready = adv;

	// DIV_STEP steps of restoring division; returns {remainder, dividend/quotient}
	function automatic logic [63:0] div_step(logic [31:0] rem, logic [31:0] nq,
			logic [31:0] dvs);
		logic [32:0] trial;
		logic [31:0] r, n;
		r = rem;
		n = nq;
		for (int i = 0; i < rvx_pkg::DIV_STEP; i++) begin
			trial = {r, n[31]};
			if (trial >= {1'b0, dvs}) begin
				trial = trial - {1'b0, dvs};
				n     = {n[30:0], 1'b1};
			end else begin
				n     = {n[30:0], 1'b0};
			end
			r = trial[31:0];
		end
		return {r, n};
	endfunction

	// signed/unsigned 33x33 multiply, low 64 bits kept
	always_comb begin
		sa = {(q_uop.funct3 == 3'd1 || q_uop.funct3 == 3'd2) && q_uop.opa[31], q_uop.opa};
		sb = {(q_uop.funct3 == 3'd1) && q_uop.opb[31], q_uop.opb};
		prod_w = $signed(sa) * $signed(sb);
		prod_c = prod_w[63:0];
	end

	// operand magnitudes for the divider
	always_comb begin
		sgn = !q_uop.funct3[0];
		ma  = (sgn && q_uop.opa[31]) ? (32'd0 - q_uop.opa) : q_uop.opa;
		mb  = (sgn && q_uop.opb[31]) ? (32'd0 - q_uop.opb) : q_uop.opb;
	end

	// divider / carry pipeline
	always_ff @(posedge clk) begin
		if (adv) begin
			u_s[1]                 <= q_uop;
			prod_s[1]              <= prod_c;
			{rem_s[1], quo_s[1]}   <= div_step(32'd0, ma, mb);
			dvs_s[1]               <= mb;
			for (int k = 2; k <= rvx_pkg::DIV_STAGES; k++) begin
				u_s[k]               <= u_s[k-1];
				prod_s[k]            <= prod_s[k-1];
				{rem_s[k], quo_s[k]} <= div_step(rem_s[k-1], quo_s[k-1], dvs_s[k-1]);
				dvs_s[k]             <= dvs_s[k-1];
			end
		end
	end

	// result select
	always_comb begin
		rvx_pkg::uop_t u;
		logic [31:0] a, b, sum, qv, rv, dres;
		logic [4:0]  sh;
		logic        lts, ltu, take, dz, dsg;
		u   = u_s[rvx_pkg::DIV_STAGES];
		a   = u.opa;
		b   = u.opb;
		sum = a + b;
		sh  = b[4:0];
		lts = $signed(a) < $signed(b);
		ltu = a < b;
		qv  = quo_s[rvx_pkg::DIV_STAGES];
		rv  = rem_s[rvx_pkg::DIV_STAGES];
		dz  = (b == 32'd0);
		dsg = !u.funct3[0];
		// divide by zero and signed fix-up of the magnitudes
		if (!u.funct3[1]) begin
			if (dz) dres = rvx_pkg::ALL_ONES;
			else dres = (dsg && (a[31] ^ b[31])) ? (32'd0 - qv) : qv;
		end else begin
			if (dz) dres = a;
			else dres = (dsg && a[31]) ? (32'd0 - rv) : rv;
		end
		res_c.invalid = 1'b0;
		case (u.funct3)
			3'd0: take = (a == b);
			3'd1: take = (a != b);
			3'd4: take = lts;
			3'd5: take = !lts;
			3'd6: take = ltu;
			default: take = !ltu;
		endcase
		case (u.op)
			rvx_pkg::OP_ADD:    res_c.result = sum;
			rvx_pkg::OP_SUB:    res_c.result = a - b;
			rvx_pkg::OP_SLL:    res_c.result = a << sh;
			rvx_pkg::OP_SLT:    res_c.result = {31'd0, lts};
			rvx_pkg::OP_SLTU:   res_c.result = {31'd0, ltu};
			rvx_pkg::OP_XOR:    res_c.result = a ^ b;
			rvx_pkg::OP_SRL:    res_c.result = a >> sh;
			rvx_pkg::OP_SRA:    res_c.result = 32'($signed(a) >>> sh);
			rvx_pkg::OP_OR:     res_c.result = a | b;
			rvx_pkg::OP_AND:    res_c.result = a & b;
			rvx_pkg::OP_MUL:    res_c.result = (u.funct3 == 3'd0)
			                                   ? prod_s[rvx_pkg::DIV_STAGES][31:0]
			                                   : prod_s[rvx_pkg::DIV_STAGES][63:32];
			rvx_pkg::OP_DIV:    res_c.result = dres;
			rvx_pkg::OP_ADDR:   res_c.result = {sum[31:1], sum[0] & !u.clr_lsb};
			rvx_pkg::OP_BRANCH: res_c.result = u.pc + (take ? u.imm : 32'd4);
			rvx_pkg::OP_PASS:   res_c.result = b;
			default: begin
				res_c.result  = rvx_pkg::ALL_ONES;
				res_c.invalid = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv && v_s[rvx_pkg::DIV_STAGES]) out_res <= res_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s     <= '0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s     <= {v_s[rvx_pkg::DIV_STAGES-1:1], q_valid};
			out_v_q <= v_s[rvx_pkg::DIV_STAGES];
		end
	end

	assign out_valid = out_v_q;

`ifndef ASSERT_OFF
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_ready) |=> out_v_q && $stable(out_res))
		else $error("result changed while stalled");
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_res.invalid) |-> out_res.result == rvx_pkg::ALL_ONES)
		else $error("invalid result not all ones");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s[rvx_pkg::DIV_STAGES]) |=> out_v_q)
		else $error("last stage item lost");
`endif

endmodule
